FILE: sv/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/biq_pkg.sv
// Shared types, codes and the microcode table of the biquad filter.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package biq_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 32;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam int COEF_W     = 32;
    localparam int N_REGS     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int DIGIT_BITS = 32;   // operand digit fed to the multiplier
    localparam int DIGIT_W    = 2;    // at most four digits per operand
    localparam int PROD_W     = COEF_W + DIGIT_BITS + 1;
    localparam int STEP_W     = 3;
    localparam int OP_W       = 2;
    localparam int OPND_W     = 3;

    // Configuration register indexes, also used as coefficient selects.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_GAIN = 3'd5;

    localparam logic [COEF_W-1:0] COEF_UNITY = 32'h1000_0000;

    // Microcode operations.
    localparam logic [OP_W-1:0] OP_NOP = 2'd0;
    localparam logic [OP_W-1:0] OP_MAC = 2'd1;
    localparam logic [OP_W-1:0] OP_FIN = 2'd2;

    // Multiplier operand selects.
    localparam logic [OPND_W-1:0] OPND_X  = 3'd0;
    localparam logic [OPND_W-1:0] OPND_X1 = 3'd1;
    localparam logic [OPND_W-1:0] OPND_X2 = 3'd2;
    localparam logic [OPND_W-1:0] OPND_Y1 = 3'd3;
    localparam logic [OPND_W-1:0] OPND_Y2 = 3'd4;
    localparam logic [OPND_W-1:0] OPND_FF = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CFG_IDX_W-1:0] coef_sel;
        logic [OPND_W-1:0]    opnd_sel;
        logic                 acc_fb;    // 1: feedback accumulator
        logic                 clr;       // first product overwrites the accumulator
        logic                 ld_ff;     // capture the scaled feedforward sum
    } t_uop;

    typedef struct packed {
        logic                 mac;
        logic [CFG_IDX_W-1:0] coef_sel;
        logic [OPND_W-1:0]    opnd_sel;
        logic                 acc_fb;
        logic                 clr;
        logic                 ld_ff;
        logic                 fin;
        logic [DIGIT_W-1:0]   digit;
        logic                 top_digit; // most significant digit, taken as signed
    } t_ctl;

    function automatic logic [COEF_W-1:0] reg_reset(input logic [CFG_IDX_W-1:0] idx);
        logic [COEF_W-1:0] v;
        unique case (idx)
            REG_COEF_X0:   v = COEF_UNITY;
            REG_FEED_GAIN: v = COEF_UNITY;
            default:       v = '0;
        endcase
        return v;
    endfunction

    // Filter program. The feedforward products go first, then the feedback
    // products of the old outputs, so that the feedforward sum has settled before it is scaled and reused.
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            3'd0:    u = '{OP_MAC, REG_COEF_X0,   OPND_X,  1'b0, 1'b1, 1'b0};
            3'd1:    u = '{OP_MAC, REG_COEF_X1,   OPND_X1, 1'b0, 1'b0, 1'b0};
            3'd2:    u = '{OP_MAC, REG_COEF_X2,   OPND_X2, 1'b0, 1'b0, 1'b0};
            3'd3:    u = '{OP_MAC, REG_COEF_Y1,   OPND_Y1, 1'b1, 1'b1, 1'b0};
            3'd4:    u = '{OP_MAC, REG_COEF_Y2,   OPND_Y2, 1'b1, 1'b0, 1'b1};
            3'd5:    u = '{OP_MAC, REG_FEED_GAIN, OPND_FF, 1'b1, 1'b0, 1'b0};
            3'd6:    u = '{OP_NOP, REG_COEF_X0,   OPND_X,  1'b0, 1'b0, 1'b0};
            default: u = '{OP_FIN, REG_COEF_X0,   OPND_X,  1'b0, 1'b0, 1'b0};
        endcase
        return u;
    endfunction

endpackage

FILE: sv/biquad_iir_filter_with_gain.sv
// Top level of the direct-form-I biquad filter with feedforward gain.
// Depends on biq_pkg, biq_seq and biq_dp.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready     | i_command, i_sample_in
//  output   | o_out_valid / i_out_ready   | o_sample_out, o_saturated
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A sample item keeps the block busy from acceptance until its result is
// loaded; no other item is taken meanwhile. The single multiplier works
// through each operand in 32-bit digits, one digit product per cycle.
// A clear item is done in the cycle it is accepted and yields no result.
// Reset is synchronous and active low; it loads the coefficient defaults and
// zeroes the history. A stalled output holds the sequencer on its last step.
module biquad_iir_filter_with_gain #(
    parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_command,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       o_sample_out,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [biq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [biq_pkg::COEF_W-1:0]           i_cfg_data
);

    logic [biq_pkg::COEF_W-1:0]      r_coef [biq_pkg::N_REGS];
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_sample_out;
    logic                            r_saturated;

    logic                            v_busy, v_in_acc, v_start, v_clear, v_out_free;
    logic signed [SAMPLE_WIDTH-1:0]  v_y;
    logic                            v_sat;
    biq_pkg::t_ctl                   v_ctl;

    // Items are taken only while the sequencer is idle. A clear item never
    // starts the sequencer, so the block is ready again in the next cycle.
    assign o_in_ready = !v_busy;
    assign v_in_acc   = i_in_valid && o_in_ready;
    assign v_start    = v_in_acc && !i_command;
    assign v_clear    = v_in_acc && i_command;

    // The output register frees itself in the cycle its item is taken, so a
    // new result can replace it without a bubble.
    assign v_out_free = !r_out_valid || i_out_ready;

    // Coefficient registers. Writes to indexes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < biq_pkg::N_REGS; k++) begin
            if (!i_rst_n) begin
                r_coef[k] <= biq_pkg::reg_reset(biq_pkg::CFG_IDX_W'(k));
            end else if (i_cfg_valid && (i_cfg_index == biq_pkg::CFG_IDX_W'(k))) begin
                r_coef[k] <= i_cfg_data;
            end
        end
    end

    biq_seq #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (v_start),
        .i_out_free (v_out_free),
        .o_busy     (v_busy),
        .o_ctl      (v_ctl)
    );

    biq_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (v_start),
        .i_clear  (v_clear),
        .i_sample (i_sample_in),
        .i_ctl    (v_ctl),
        .i_coef   (r_coef),
        .o_y      (v_y),
        .o_sat    (v_sat)
    );

    // Result register: loaded on the final step, cleared once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (v_ctl.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_ctl.fin) begin
            r_sample_out <= v_y;
            r_saturated  <= v_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

endmodule

FILE: sv/biq_seq.sv
// Microcode sequencer: step counter, digit counter and control word decode.
// Depends on biq_pkg for the program table and the control struct.
module biq_seq #(
    parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_free,
    output logic          o_busy,
    output biq_pkg::t_ctl o_ctl
);

    localparam int FFW     = SAMPLE_WIDTH + 34 - COEF_FRAC_BITS;
    localparam int NDIG_S  = (SAMPLE_WIDTH + biq_pkg::DIGIT_BITS - 1) / biq_pkg::DIGIT_BITS;
    localparam int NDIG_FF = (FFW + biq_pkg::DIGIT_BITS - 1) / biq_pkg::DIGIT_BITS;
    localparam logic [biq_pkg::DIGIT_W-1:0] LAST_S  = biq_pkg::DIGIT_W'(NDIG_S - 1);
    localparam logic [biq_pkg::DIGIT_W-1:0] LAST_FF = biq_pkg::DIGIT_W'(NDIG_FF - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          r_state, n_state;
    logic [biq_pkg::STEP_W-1:0]    r_step, n_step;
    logic [biq_pkg::DIGIT_W-1:0]   r_digit, n_digit;
    biq_pkg::t_uop                 v_uop;
    logic                          v_last_dig;

    assign v_uop      = biq_pkg::ucode(r_step);
    assign v_last_dig = (r_digit == ((v_uop.opnd_sel == biq_pkg::OPND_FF) ? LAST_FF : LAST_S));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_digit = r_digit;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                    n_digit = '0;
                end
            end
            ST_RUN: begin
                case (v_uop.op)
                    biq_pkg::OP_MAC: begin
                        if (v_last_dig) begin
                            n_digit = '0;
                            n_step  = r_step + 1'b1;
                        end else begin
                            n_digit = r_digit + 1'b1;
                        end
                    end
                    biq_pkg::OP_FIN: begin
                        // Wait here until the output register can take the result.
                        if (i_out_free) begin
                            n_state = ST_IDLE;
                            n_step  = '0;
                        end
                    end
                    default: n_step = r_step + 1'b1;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_digit <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_digit <= n_digit;
        end
    end

    always_comb begin
        o_ctl.mac       = (r_state == ST_RUN) && (v_uop.op == biq_pkg::OP_MAC);
        o_ctl.coef_sel  = v_uop.coef_sel;
        o_ctl.opnd_sel  = v_uop.opnd_sel;
        o_ctl.acc_fb    = v_uop.acc_fb;
        o_ctl.clr       = v_uop.clr && (r_digit == '0);
        o_ctl.ld_ff     = (r_state == ST_RUN) && v_uop.ld_ff;
        o_ctl.fin       = (r_state == ST_RUN) && (v_uop.op == biq_pkg::OP_FIN) && i_out_free;
        o_ctl.digit     = r_digit;
        o_ctl.top_digit = v_last_dig;
    end

    assign o_busy = (r_state == ST_RUN);

endmodule

FILE: sv/biq_dp.sv
// Datapath: one 32x33 multiplier, two accumulators, history and saturation.
// Depends on biq_pkg; driven by the control struct of biq_seq.
module biq_dp #(
    parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_clear,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  biq_pkg::t_ctl                   i_ctl,
    input  logic [biq_pkg::COEF_W-1:0]      i_coef [biq_pkg::N_REGS],
    output logic signed [SAMPLE_WIDTH-1:0]  o_y,
    output logic                            o_sat
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int F       = COEF_FRAC_BITS;
    localparam int FFW     = SW + 34 - F;
    localparam int NDIG_FF = (FFW + biq_pkg::DIGIT_BITS - 1) / biq_pkg::DIGIT_BITS;
    localparam int OPW     = NDIG_FF * biq_pkg::DIGIT_BITS;
    localparam int ACCW    = (SW + 68 - F > biq_pkg::PROD_W) ? SW + 68 - F : biq_pkg::PROD_W;
    localparam int HIW     = ACCW - (SW - 1 + F);

    logic signed [SW-1:0]                   r_x, r_x1, r_x2, r_y1, r_y2;
    logic signed [FFW-1:0]                  r_ff;
    logic signed [ACCW-1:0]                 r_acc_ff, r_acc_fb;
    logic signed [biq_pkg::PROD_W-1:0]      r_prod;
    logic                                   r_pv, r_pfb, r_pclr;
    logic [biq_pkg::DIGIT_W-1:0]            r_pdig;

    logic signed [OPW-1:0]                  v_opx;
    logic [biq_pkg::DIGIT_BITS-1:0]         v_slice;
    logic signed [biq_pkg::DIGIT_BITS:0]    v_dig;
    logic signed [biq_pkg::COEF_W-1:0]      v_coef;
    logic signed [biq_pkg::PROD_W-1:0]      v_prod;
    logic signed [ACCW-1:0]                 v_addend;
    logic [HIW-1:0]                         v_hi;
    logic                                   v_fits;

    always_comb begin
        case (i_ctl.opnd_sel)
            biq_pkg::OPND_X1: v_opx = OPW'(r_x1);
            biq_pkg::OPND_X2: v_opx = OPW'(r_x2);
            biq_pkg::OPND_Y1: v_opx = OPW'(r_y1);
            biq_pkg::OPND_Y2: v_opx = OPW'(r_y2);
            biq_pkg::OPND_FF: v_opx = OPW'(r_ff);
            default:          v_opx = OPW'(r_x);
        endcase
        case (i_ctl.coef_sel)
            biq_pkg::REG_COEF_X1:   v_coef = i_coef[1];
            biq_pkg::REG_COEF_X2:   v_coef = i_coef[2];
            biq_pkg::REG_COEF_Y1:   v_coef = i_coef[3];
            biq_pkg::REG_COEF_Y2:   v_coef = i_coef[4];
            biq_pkg::REG_FEED_GAIN: v_coef = i_coef[5];
            default:                v_coef = i_coef[0];
        endcase
    end

    // Lower digits are unsigned, the top digit carries the operand's sign.
    assign v_slice  = biq_pkg::DIGIT_BITS'(v_opx >>> (i_ctl.digit * biq_pkg::DIGIT_BITS));
    assign v_dig    = {i_ctl.top_digit & v_slice[biq_pkg::DIGIT_BITS-1], v_slice};
    assign v_prod   = v_coef * v_dig;
    assign v_addend = ACCW'(r_prod) <<< (r_pdig * biq_pkg::DIGIT_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac) begin
            r_prod <= v_prod;
            r_pfb  <= i_ctl.acc_fb;
            r_pclr <= i_ctl.clr;
            r_pdig <= i_ctl.digit;
        end
        if (r_pv && !r_pfb) begin
            r_acc_ff <= (r_pclr ? '0 : r_acc_ff) + v_addend;
        end
        if (r_pv && r_pfb) begin
            r_acc_fb <= (r_pclr ? '0 : r_acc_fb) + v_addend;
        end
        if (i_ctl.ld_ff) begin
            r_ff <= r_acc_ff[F +: FFW];
        end
        if (i_start) begin
            r_x <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_ctl.fin) begin
            r_x2 <= r_x1;
            r_x1 <= r_x;
            r_y2 <= r_y1;
            r_y1 <= o_y;
        end
    end

    // The scaled sum fits when every bit from the output sign upward agrees.
    assign v_hi   = r_acc_fb[ACCW-1:SW-1+F];
    assign v_fits = (&v_hi) | ~(|v_hi);

    always_comb begin
        if (v_fits) begin
            o_y = r_acc_fb[F +: SW];
        end else if (r_acc_fb[ACCW-1]) begin
            o_y = {1'b1, {(SW-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(SW-1){1'b1}}};
        end
        o_sat = !v_fits;
    end

endmodule

FILE: sv/biq_chk.sv
// Port-level checker for the biquad filter, bound to the top level.
// Depends on assert_macros.svh and biq_pkg.
`include "assert_macros.svh"

module biq_chk #(
    parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_command,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0]     o_sample_out,
    input logic                               o_saturated
);

    localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // A sample item makes the block busy and drops input ready.
    `ASSERT_NEXT(a_busy_after_sample, i_clk, i_rst_n,
        i_in_valid && o_in_ready && !i_command, !o_in_ready,
        "input still ready after a sample item")

    // A clear item finishes at once.
    `ASSERT_NEXT(a_ready_after_clear, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_command, o_in_ready,
        "clear item blocked the input")

    // A clipped result is one of the two range limits.
    `ASSERT_SAME(a_sat_at_limit, i_clk, i_rst_n,
        o_out_valid && o_saturated,
        (o_sample_out == SMAX) || (o_sample_out == SMIN),
        "saturated result is not at a range limit")

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_sample_out) && $stable(o_saturated),
        "stalled result changed")

endmodule

bind biquad_iir_filter_with_gain biq_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_command    (i_command),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out),
    .o_saturated  (o_saturated)
);

FILE: bench/testbench.sv
// Self-checking bench for the biquad filter with feedforward gain: a queue-fed
// driver, a ready-toggling monitor and a bit-exact predictor of the filter.
// Depends on biq_pkg and biquad_iir_filter_with_gain.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW        = biq_pkg::SAMPLE_WIDTH_DEF;
    localparam int FRAC      = biq_pkg::COEF_FRAC_BITS_DEF;
    localparam int HALF_PER  = 10;
    localparam int RST_CYC   = 5;
    // Settling time after the last result, leaving a wide margin for any work
    // still in flight.
    localparam int SETTLE_CYCLES = 30;
    // Hang limit, above the slowest correct run: about 2000 items, each with
    // the longest send gap, its own processing and the longest output stall.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_SPARE_A =
        biq_pkg::CFG_IDX_W'(biq_pkg::N_REGS);
    localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_SPARE_B =
        biq_pkg::CFG_IDX_W'(biq_pkg::N_REGS + 1);

    localparam logic signed [SW-1:0]  SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]  SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [127:0]   WIDE_MAX   = 128'sd2147483647;
    localparam logic signed [127:0]   WIDE_MIN   = -128'sd2147483648;

    // Coefficient pick modes for the random phases.
    localparam int COEF_STABLE  = 0;
    localparam int COEF_ANY     = 1;
    localparam int COEF_EXTREME = 2;

    typedef struct packed {
        logic                 cmd;
        logic signed [SW-1:0] sample;
    } t_filt_item;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 sat;
    } t_filt_result;

    // DUT connections. Every input starts at a known value.
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic                              i_command   = CMD_SAMPLE;
    logic signed [SW-1:0]              i_sample_in = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [SW-1:0]              o_sample_out;
    logic                              o_saturated;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [biq_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [biq_pkg::COEF_W-1:0]        i_cfg_data  = '0;

    // Predictor state: shadow of the coefficient bank and the four history
    // registers, updated whenever the DUT accepts a config write or an item.
    logic signed [biq_pkg::COEF_W-1:0] coef_bank [biq_pkg::N_REGS];
    logic signed [SW-1:0]              hist_x1, hist_x2, hist_y1, hist_y2;

    t_filt_item   pending_q [$];   // items still to be offered to the DUT
    t_filt_result filt_out_q [$];  // predicted outputs not yet seen

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap    = 0;
    int unsigned recv_gap    = 0;
    logic        no_idle     = 1'b0;   // set for a phase run at full rate

    biquad_iir_filter_with_gain u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_saturated  (o_saturated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(HALF_PER) i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Sign-extends a 32-bit value to the width where every product and sum
    // of the filter is exact.
    function automatic logic signed [127:0] widen(input logic signed [31:0] v);
        logic signed [127:0] w;
        w = v;
        return w;
    endfunction

    // One accepted item. A clear zeroes the history and yields nothing; a
    // sample computes the feedforward sum, scales it, applies the gain, adds
    // the feedback terms, scales again (floor) and clips to the sample range.
    // The clipped value is what goes into the output history.
    function automatic void filter_step(input logic cmd, input logic signed [SW-1:0] x);
        logic signed [127:0] ff;
        logic signed [127:0] acc;
        t_filt_result        res;
        if (cmd == CMD_CLEAR) begin
            hist_x1 = '0;
            hist_x2 = '0;
            hist_y1 = '0;
            hist_y2 = '0;
        end else begin
            ff = widen(coef_bank[biq_pkg::REG_COEF_X0]) * widen(x)
               + widen(coef_bank[biq_pkg::REG_COEF_X1]) * widen(hist_x1)
               + widen(coef_bank[biq_pkg::REG_COEF_X2]) * widen(hist_x2);
            ff = ff >>> FRAC;
            acc = widen(coef_bank[biq_pkg::REG_FEED_GAIN]) * ff
                + widen(coef_bank[biq_pkg::REG_COEF_Y1]) * widen(hist_y1)
                + widen(coef_bank[biq_pkg::REG_COEF_Y2]) * widen(hist_y2);
            acc = acc >>> FRAC;
            res.sat = 1'b1;
            if (acc > WIDE_MAX) begin
                res.value = SAMPLE_MAX;
            end else if (acc < WIDE_MIN) begin
                res.value = SAMPLE_MIN;
            end else begin
                res.value = acc[SW-1:0];
                res.sat   = 1'b0;
            end
            hist_x2 = hist_x1;
            hist_x1 = x;
            hist_y2 = hist_y1;
            hist_y1 = res.value;
            filt_out_q.push_back(res);
        end
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        int unsigned len;
        roll = $urandom_range(0, 99);
        if (roll < 60)      len = 0;
        else if (roll < 92) len = $urandom_range(1, 3);
        else                len = $urandom_range(10, 40);
        return len;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        int unsigned          roll;
        logic signed [SW-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            v = $urandom;
        end else if (roll < 85) begin
            v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        end else begin
            case ($urandom_range(0, 4))
                0:       v = SAMPLE_MAX;
                1:       v = SAMPLE_MIN;
                2:       v = '0;
                3:       v = -1;
                default: v = 1;
            endcase
        end
        return v;
    endfunction

    function automatic logic [biq_pkg::COEF_W-1:0] pick_coef(input int mode);
        logic [biq_pkg::COEF_W-1:0] c;
        if (mode == COEF_STABLE) begin
            // Within +-0.25 so that most runs stay out of saturation.
            c = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        end else if (mode == COEF_ANY) begin
            c = $urandom;
        end else begin
            case ($urandom_range(0, 4))
                0:       c = 32'h7FFF_FFFF;
                1:       c = 32'h8000_0000;
                2:       c = '0;
                3:       c = biq_pkg::COEF_UNITY;
                default: c = -biq_pkg::COEF_UNITY;
            endcase
        end
        return c;
    endfunction

    task automatic push_sample(input logic signed [SW-1:0] x);
        pending_q.push_back('{cmd: CMD_SAMPLE, sample: x});
    endtask

    task automatic push_clear();
        // The sample field of a clear is random; the block must ignore it.
        pending_q.push_back('{cmd: CMD_CLEAR, sample: $urandom});
    endtask

    // One register write over the config channel. The shadow bank follows
    // only indexes that exist.
    task automatic write_reg(input logic [biq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [biq_pkg::COEF_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < biq_pkg::N_REGS) coef_bank[idx] = data;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [biq_pkg::COEF_W-1:0] data);
        for (int r = biq_pkg::REG_COEF_X0; r <= biq_pkg::REG_FEED_GAIN; r++)
            write_reg(biq_pkg::CFG_IDX_W'(r), data);
    endtask

    // Waits until every item has gone in and every predicted output has come
    // out, then lets the block settle so that a trailing clear is finished.
    // Sampling on the falling edge keeps this clear of the clocked blocks.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || filt_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver. An item is taken when valid and ready are both high at
    // the edge; the payload is read back from the driven ports, which still
    // hold the accepted values at that point. A new item or an idle gap is
    // only chosen when nothing is waiting on the channel.
    always @(posedge i_clk) begin : input_driver
        t_filt_item item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) filter_step(i_command, i_sample_in);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    item = pending_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_command   <= item.cmd;
                    i_sample_in <= item.sample;
                    send_gap    = no_idle ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each result taken is checked against the oldest
    // prediction, field by field; ready is stalled at random.
    always @(posedge i_clk) begin : output_monitor
        t_filt_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filt_out_q.size() == 0) begin
                report_error($sformatf("unexpected output %h sat %b", o_sample_out, o_saturated));
            end else begin
                want = filt_out_q.pop_front();
                if (o_sample_out !== want.value)
                    report_error($sformatf("sample_out %h, predicted %h",
                                           o_sample_out, want.value));
                if (o_saturated !== want.sat)
                    report_error($sformatf("saturated %b, predicted %b (out %h)",
                                           o_saturated, want.sat, want.value));
            end
        end
        if (no_idle || recv_gap == 0) begin
            i_out_ready <= 1'b1;
            recv_gap = no_idle ? 0 : pick_gap();
        end else begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        // Shadow state matches the block after reset: unity on the current
        // input and on the gain, everything else zero.
        for (int r = 0; r < biq_pkg::N_REGS; r++) coef_bank[r] = '0;
        coef_bank[biq_pkg::REG_COEF_X0]   = biq_pkg::COEF_UNITY;
        coef_bank[biq_pkg::REG_FEED_GAIN] = biq_pkg::COEF_UNITY;
        hist_x1 = '0;
        hist_x2 = '0;
        hist_y1 = '0;
        hist_y2 = '0;

        repeat (RST_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset coefficients: the block passes samples
        // through, so the field extremes come out unchanged. The clear in
        // the middle must yield no output and wipe the history.
        push_sample('0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(-1);
        push_clear();
        push_sample(1);
        push_sample(32'sh1234_5678);
        wait_drained();

        // All weights at their most positive: large inputs must clip high
        // and low, and the clipped value feeds back through y1. A write to
        // an index past the bank must leave the weights alone.
        write_all(32'h7FFF_FFFF);
        write_reg(REG_SPARE_A, '0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_clear();
        push_sample(SAMPLE_MIN);
        push_sample(1);
        wait_drained();

        // All weights at their most negative, and the other spare index.
        write_all(32'h8000_0000);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample('0);
        push_sample(1);
        push_clear();
        push_sample(-1);
        wait_drained();

        // Random phases. Each one loads a new coefficient set while the block
        // is idle, so the sender waits for all outputs between phases. One
        // phase runs with no idling on either side.
        for (int p = 0; p < PHASES; p++) begin
            no_idle = (p == 3);
            for (int r = biq_pkg::REG_COEF_X0; r <= biq_pkg::REG_FEED_GAIN; r++)
                write_reg(biq_pkg::CFG_IDX_W'(r), pick_coef(p % 3));
            if ($urandom_range(0, 1) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 5) push_clear();
                else                           push_sample(pick_sample());
            end
            wait_drained();
        end
        no_idle = 1'b0;

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
